@@ hdl/ghcb_pkg.sv @@
// Package for the Gear-hash chunk boundary block: register indexes, field widths
// and the 256-entry Gear constant table.
// No dependencies; used by gear_hash_chunk_boundary.
package ghcb_pkg;

    // Widths of the registers and stream fields.
    localparam int CFG_LEN_W  = 21;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int FP_W       = 64;
    localparam int BYTE_W     = 8;
    localparam int OUT_LEN_W  = 21;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    // Register indexes on the write port.
    localparam logic [CFG_IDX_W-1:0] IDX_MIN_CHUNK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_MAX_CHUNK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_CUT_MASK  = 2'd2;

    // Reset values of the registers.
    localparam logic [CFG_LEN_W-1:0] MIN_CHUNK_RESET = 21'd2048;
    localparam logic [CFG_LEN_W-1:0] MAX_CHUNK_RESET = 21'd65536;
    localparam logic [FP_W-1:0]      CUT_MASK_RESET  = 64'd8191;

    // Gear table generator: xorshift64 with shifts 13, 7 and 17.
    localparam logic [FP_W-1:0] GEAR_SEED    = 64'h1234_5678_9ABC_DEF0;
    localparam int              GEAR_ENTRIES = 256;

    typedef logic [GEAR_ENTRIES-1:0][FP_W-1:0] gear_table_t;

    // Evaluated once at elaboration to fill the constant table.
    function automatic gear_table_t build_gear();
        logic [FP_W-1:0] s;
        gear_table_t     t;
        s = GEAR_SEED;
        for (int i = 0; i < GEAR_ENTRIES; i++)
        begin
            s = s ^ (s << 13);
            s = s ^ (s >> 7);
            s = s ^ (s << 17);
            t[i] = s;
        end
        return t;
    endfunction

    localparam gear_table_t GEAR_TABLE = build_gear();

endpackage

@@ hdl/gear_hash_chunk_boundary.sv @@
// Gear-hash content-defined chunk boundary detector, top level.
// Depends on ghcb_pkg for the Gear table, register indexes and widths.
//
// Channel    Dir  Handshake               Payload
// s_axis     in   tvalid/tready           tdata[7:0] data_byte, tlast last_byte
// m_axis     out  tvalid/tready           tdata[20:0] chunk_length, tuser forced_cut,
//                                         tlast payload_end
// config     in   cfg_we (no wait)        cfg_index, cfg_data
//
// One byte is accepted every cycle while m_axis does not stall. Each byte is held in the
// input register; the fingerprint and length update and the boundary test then run
// combinationally, and their outcome is loaded into the result register as the byte
// leaves the input register.
// The combinational fingerprint loop (table lookup, shift-add, mask test) sets this rate.
// Reset clears the fingerprint, the length and the valid flags, and loads the register
// defaults. A stall on m_axis holds the result and stops the input register from
// advancing, which drops s_axis_tready once it is full.
module gear_hash_chunk_boundary #(
    parameter int LENGTH_BOUND = 1048576
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ghcb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tlast,  // last_byte
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ghcb_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [20:0] chunk_length, [23:21] 0
    output logic                           m_axis_tuser,  // [0] forced_cut
    output logic                           m_axis_tlast,  // payload_end
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [ghcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ghcb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ghcb_pkg::*;

    // Length counter holds up to LENGTH_BOUND; compares run at the wider of that
    // and the register width.
    localparam int LEN_W = $clog2(LENGTH_BOUND + 1);
    localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

    // Configuration registers.
    logic [CFG_LEN_W-1:0] min_chunk_reg;
    logic [CFG_LEN_W-1:0] max_chunk_reg;
    logic [FP_W-1:0]      cut_mask_reg;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Chunk state.
    logic [FP_W-1:0]  fp_reg;
    logic [FP_W-1:0]  fp_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;

    // Result register.
    logic                 out_valid_reg;
    logic [OUT_LEN_W-1:0] out_len_reg;
    logic                 out_forced_reg;
    logic                 out_end_reg;

    // Datapath signals.
    logic             advance;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] len_inc;
    logic             hash_en;
    logic [FP_W-1:0]  fp_hash;
    logic             content_cut;
    logic             forced_cut;
    logic             cut;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_chunk_reg <= MIN_CHUNK_RESET;
            max_chunk_reg <= MAX_CHUNK_RESET;
            cut_mask_reg  <= CUT_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                IDX_MIN_CHUNK: min_chunk_reg <= cfg_data[CFG_LEN_W-1:0];
                IDX_MAX_CHUNK: max_chunk_reg <= cfg_data[CFG_LEN_W-1:0];
                IDX_CUT_MASK:  cut_mask_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The input register moves on whenever the result register is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata[BYTE_W-1:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    // Effective limit: max_chunk clipped to LENGTH_BOUND, with zero acting as one.
    always_comb
    begin
        limit = CMP_W'(max_chunk_reg);
        if (limit > CMP_W'(LENGTH_BOUND))
        begin
            limit = CMP_W'(LENGTH_BOUND);
        end
        if (limit == '0)
        begin
            limit = CMP_W'(1);
        end
    end

    // Fingerprint update and boundary test for the byte in the input register.
    always_comb
    begin
        len_inc     = CMP_W'(len_reg) + CMP_W'(1);
        hash_en     = len_inc > CMP_W'(min_chunk_reg);
        fp_hash     = (fp_reg << 1) + GEAR_TABLE[in_byte_reg];
        content_cut = hash_en && ((fp_hash & cut_mask_reg) == '0);
        forced_cut  = !content_cut && (len_inc >= limit);
        cut         = content_cut || forced_cut || in_last_reg;

        if (cut)
        begin
            fp_next  = '0;
            len_next = '0;
        end
        else
        begin
            fp_next  = hash_en ? fp_hash : fp_reg;
            len_next = len_inc[LEN_W-1:0];
        end
    end

    // Chunk state advances with each byte that leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg  <= '0;
            len_reg <= '0;
        end
        else if (advance)
        begin
            fp_reg  <= fp_next;
            len_reg <= len_next;
        end
    end

    // Result register: loaded on a cut, cleared once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cut;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cut)
        begin
            out_len_reg    <= len_inc[OUT_LEN_W-1:0];
            out_forced_reg <= forced_cut;
            out_end_reg    <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_len_reg);
    assign m_axis_tuser  = out_forced_reg;
    assign m_axis_tlast  = out_end_reg;

endmodule

@@ tb/sv/tb.sv @@
// Testbench for gear_hash_chunk_boundary: streams payload bytes, predicts chunk cuts
// with its own Gear fingerprint model and checks every result item.
// Depends on ghcb_pkg for widths, register indexes and the Gear seed.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ghcb_pkg::*;

    localparam int LEN_CAP = 1048576;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] len;
        logic                 forced;
        logic                 pend;
    } chunk_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = IDX_MIN_CHUNK;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: register copies, fingerprint and running chunk length.
    logic [CFG_LEN_W-1:0] min_len = MIN_CHUNK_RESET;
    logic [CFG_LEN_W-1:0] max_len = MAX_CHUNK_RESET;
    logic [FP_W-1:0]      cut_bits = CUT_MASK_RESET;
    logic [FP_W-1:0]      fp = '0;
    logic [CFG_LEN_W-1:0] run_len = '0;
    logic [FP_W-1:0]      gear_lut [GEAR_ENTRIES];

    chunk_t pending_chunks[$];
    int     err_count = 0;
    bit     no_idle = 1'b0;

    gear_hash_chunk_boundary #(
        .LENGTH_BOUND(LEN_CAP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gear table from the xorshift64 generator, filled before any byte is sent.
    initial
    begin : fill_gear
        logic [FP_W-1:0] x;
        x = GEAR_SEED;
        for (int k = 0; k < GEAR_ENTRIES; k++)
        begin
            x ^= {x[50:0], 13'd0};
            x ^= {7'd0, x[63:7]};
            x ^= {x[46:0], 17'd0};
            gear_lut[k] = x;
        end
    end

    // Advance the chunker by one byte and queue the chunk it closes, if any.
    task automatic predict_cut(input logic [7:0] b, input logic last);
        logic [CFG_LEN_W-1:0] limit;
        logic [CFG_LEN_W-1:0] len;
        logic                 hit;
        logic                 forced;
        chunk_t               c;
        limit = (max_len > LEN_CAP) ? CFG_LEN_W'(LEN_CAP) : max_len;
        if (limit == 0)
            limit = CFG_LEN_W'(1);
        len = run_len + 1'b1;
        hit = 1'b0;
        // Bytes inside the skip region are only counted.
        if (len > min_len)
        begin
            fp  = (fp << 1) + gear_lut[b];
            hit = ((fp & cut_bits) == '0);
        end
        forced = !hit && (len >= limit);
        if (hit || forced || last)
        begin
            c.len    = len;
            c.forced = forced;
            c.pend   = last;
            pending_chunks.insert(pending_chunks.size(), c);
            fp      = '0;
            run_len = '0;
        end
        else
            run_len = len;
    endtask

    // Track register writes and accepted bytes, then check each result item.
    always @(posedge clk)
    begin
        chunk_t e;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    IDX_MIN_CHUNK: min_len = cfg_data[CFG_LEN_W-1:0];
                    IDX_MAX_CHUNK: max_len = cfg_data[CFG_LEN_W-1:0];
                    IDX_CUT_MASK:  cut_bits = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_cut(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_chunks.size() == 0)
                begin
                    $error("unexpected chunk item: chunk_length %0d forced_cut %0b payload_end %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    err_count++;
                end
                else
                begin
                    e = pending_chunks.pop_front();
                    if (m_axis_tdata !== M_TDATA_W'(e.len))
                    begin
                        $error("chunk_length: expected %0d, got %0d", e.len, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tuser !== e.forced)
                    begin
                        $error("forced_cut: expected %0b, got %0b", e.forced, m_axis_tuser);
                        err_count++;
                    end
                    if (m_axis_tlast !== e.pend)
                    begin
                        $error("payload_end: expected %0b, got %0b", e.pend, m_axis_tlast);
                        err_count++;
                    end
                end
            end
        end
    end

    // Result side back-pressure.
    always @(posedge clk)
    begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // Offer one byte, with a random gap in front, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Send a payload of random bytes, closed by a last byte.
    task automatic send_payload(input int n);
        for (int i = 1; i <= n; i++)
            send_byte(8'($urandom_range(255)), i == n);
    endtask

    // Stop sending, wait for every chunk and let the pipeline empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_chunks.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write all three registers on consecutive cycles; only call when drained.
    task automatic set_config(input logic [63:0] min_v, input logic [63:0] max_v,
                              input logic [63:0] mask_v);
        cfg_we    <= 1'b1;
        cfg_index <= IDX_MIN_CHUNK;
        cfg_data  <= min_v;
        @(posedge clk);
        cfg_index <= IDX_MAX_CHUNK;
        cfg_data  <= max_v;
        @(posedge clk);
        cfg_index <= IDX_CUT_MASK;
        cfg_data  <= mask_v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Default registers: short payloads end only on the last byte.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain();
    endtask

    // A limit of one cuts every byte; a limit of zero acts as one.
    task automatic test_one_byte_limit();
        set_config(64'd0, 64'd1, '1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        drain();
        set_config(64'd3, 64'd0, 64'd0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hED, 1'b1);
        drain();
    endtask

    // An all-zero mask cuts on every hashed byte, also at the limit itself.
    task automatic test_content_cut();
        set_config(64'd0, 64'h1F_FFFF, 64'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();
        set_config(64'd0, 64'd1, 64'd0);
        send_byte(8'h33, 1'b0);
        send_byte(8'hCC, 1'b1);
        drain();
    endtask

    // Limit below the skip region: forced cuts, nothing hashed.
    task automatic test_limit_below_minimum();
        set_config(64'h1F_FFFF, 64'd4, 64'd0);
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'hA5, 1'b1);
        drain();
    endtask

    // Random register settings, each followed by a batch of random payloads.
    task automatic test_random_chunking();
        int          sent;
        int          phase;
        int          batch;
        int          n;
        logic [63:0] min_v;
        logic [63:0] max_v;
        logic [63:0] mask_v;
        sent  = 0;
        phase = 0;
        while (sent < 1030)
        begin
            min_v = {$urandom, $urandom};
            max_v = {$urandom, $urandom};
            min_v[20:0] = ($urandom_range(9) == 0) ? 21'h1F_FFFF : 21'($urandom_range(10));
            case ($urandom_range(9))
                0:       max_v[20:0] = 21'd0;
                1:       max_v[20:0] = 21'd1;
                2:       max_v[20:0] = 21'h1F_FFFF;
                3:       max_v[20:0] = 21'(LEN_CAP);
                default: max_v[20:0] = 21'($urandom_range(2, 48));
            endcase
            case ($urandom_range(9))
                0:       mask_v = '0;
                1:       mask_v = '1;
                2:       mask_v = {$urandom, $urandom};
                default:
                begin
                    mask_v = '0;
                    repeat ($urandom_range(1, 4))
                        mask_v[$urandom_range(63)] = 1'b1;
                end
            endcase
            set_config(min_v, max_v, mask_v);
            // One stretch of the run goes with no idling on either side.
            no_idle = (phase == 3);
            batch = 0;
            while (batch < 90)
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
                send_payload(n);
                batch += n;
            end
            drain();
            sent += batch;
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_one_byte_limit();
        test_content_cut();
        test_limit_below_minimum();
        test_random_chunking();
        drain();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ghcb_pkg.sv
hdl/gear_hash_chunk_boundary.sv
tb/sv/tb.sv
